>>> rtl/core/lfsa_pkg.sv
package lfsa_pkg;

    // fixed field widths
    localparam int OFS_W   = 17;
    localparam int LEVEL_W = 5;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // defaults for the top level parameters
    localparam int DEF_MAX_FRAMES   = 16;
    localparam int DEF_HEADER_BYTES = 4;
    localparam int DEF_ARENA_MAX    = 65536;

    // arena size after reset
    localparam logic [OFS_W-1:0] ARENA_RESET = 17'h10000;

    // register index decoded from paddr[2]
    localparam logic REG_ARENA = 1'b0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE_TO    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_BYTES = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_FRAME = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BEGIN      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END        = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNROLL     = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ARG  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OFS_W-1:0]   amount;
        logic [LEVEL_W-1:0] target_level;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFS_W-1:0]   result_offset;
        logic [LEVEL_W-1:0] frame_level;
        logic [OFS_W-1:0]   used_bytes;
        logic [OFS_W-1:0]   free_bytes;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic pop;
        logic fin;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic unroll_go;
        logic pop_last;
    } dp_sts_t;

    // configuration write
    typedef struct packed {
        logic             wr;
        logic [OFS_W-1:0] arena;
    } cfg_wr_t;

endpackage

>>> rtl/core/lfsa_ctrl.sv
module lfsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  lfsa_pkg::dp_sts_t sts,
    output lfsa_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // output register can take a new item
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.unroll_go)
                begin
                    state_next = S_POP;
                end
                else if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (sts.pop_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        priority if (cmd.exec || cmd.fin)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/core/lfsa_dpath.sv
module lfsa_dpath #(
    parameter int MAX_FRAMES   = lfsa_pkg::DEF_MAX_FRAMES,
    parameter int HEADER_BYTES = lfsa_pkg::DEF_HEADER_BYTES,
    parameter int ARENA_MAX    = lfsa_pkg::DEF_ARENA_MAX
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfsa_pkg::req_t                req,
    input  lfsa_pkg::cfg_wr_t             cfg,
    input  lfsa_pkg::dp_cmd_t             cmd,
    output lfsa_pkg::dp_sts_t             sts,
    output lfsa_pkg::rsp_t                rsp,
    output logic [lfsa_pkg::OFS_W-1:0]    arena_bytes
);

    localparam int OFS_W   = lfsa_pkg::OFS_W;
    localparam int LVL_W   = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CMP_W   = (LVL_W > lfsa_pkg::LEVEL_W) ? LVL_W : lfsa_pkg::LEVEL_W;
    localparam int OFS_MAX = (1 << OFS_W) - 1;
    localparam int ARENA_CAP = (ARENA_MAX > OFS_MAX) ? OFS_MAX : ARENA_MAX;

    localparam logic [OFS_W-1:0] HDR     = OFS_W'(HEADER_BYTES);
    localparam logic [OFS_W-1:0] CAP     = OFS_W'(ARENA_CAP);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_FRAMES);
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_TWO = LVL_W'(2);

    // architectural state
    logic [OFS_W-1:0]   arena_reg;
    logic [OFS_W-1:0]   top_reg, top_next;
    logic [OFS_W-1:0]   base_reg, base_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;

    // latched request and unroll working copies
    lfsa_pkg::req_t     req_reg;
    logic [OFS_W-1:0]   wt_reg;
    logic [OFS_W-1:0]   wb_reg;
    logic [LVL_W-1:0]   wl_reg;
    logic [lfsa_pkg::STAT_W-1:0] wst_reg;

    // saved frame bases
    logic [OFS_W-1:0]   mem [MAX_FRAMES];
    logic [OFS_W-1:0]   rd_reg;
    logic               rd_en;
    logic [LVL_W-1:0]   lvl_dec;
    logic [LVL_W-1:0]   wl_dec;
    logic [LVL_W-1:0]   wl_dec2;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_wr;

    // execute results
    logic [OFS_W-1:0]   arena;
    logic [OFS_W:0]     sum_alloc;
    logic [OFS_W:0]     sum_hdr;
    logic [OFS_W-1:0]   avail;
    logic [lfsa_pkg::STAT_W-1:0] ex_status;
    logic               alloc_ok;
    logic [OFS_W-1:0]   ex_result;

    // final values for the output register
    logic [lfsa_pkg::STAT_W-1:0] f_status;
    logic [OFS_W-1:0]   f_result;
    logic [OFS_W-1:0]   f_top;
    logic [LVL_W-1:0]   f_lvl;
    lfsa_pkg::rsp_t     rsp_reg;

    assign arena       = (arena_reg > CAP) ? CAP : arena_reg;
    assign arena_bytes = arena_reg;
    assign rsp         = rsp_reg;

    // status toward the controller
    assign wl_dec  = wl_reg - LVL_ONE;
    assign wl_dec2 = wl_reg - LVL_TWO;
    assign lvl_dec = lvl_reg - LVL_ONE;
    assign sts.unroll_go = (req_reg.kind == lfsa_pkg::KIND_UNROLL)
                        && (CMP_W'(req_reg.target_level) < CMP_W'(lvl_reg));
    assign sts.pop_last  = (wt_reg == '0)
                        || (CMP_W'(wl_dec) == CMP_W'(req_reg.target_level));

    // execute a single-update request
    always_comb
    begin
        sum_alloc = {1'b0, top_reg} + {1'b0, req_reg.amount};
        sum_hdr   = {1'b0, top_reg} + {1'b0, HDR};
        avail     = top_reg - base_reg;
        top_next  = top_reg;
        base_next = base_reg;
        lvl_next  = lvl_reg;
        ex_status = lfsa_pkg::ST_OK;
        alloc_ok  = 1'b0;
        mem_wr    = 1'b0;
        unique case (req_reg.kind)
            lfsa_pkg::KIND_ALLOC:
            begin
                if (sum_alloc > {1'b0, arena})
                begin
                    ex_status = lfsa_pkg::ST_NO_ROOM;
                end
                else
                begin
                    alloc_ok = 1'b1;
                    top_next = sum_alloc[OFS_W-1:0];
                end
            end
            lfsa_pkg::KIND_FREE_TO:
            begin
                if ((req_reg.amount < base_reg) || (req_reg.amount >= top_reg))
                begin
                    ex_status = lfsa_pkg::ST_BAD_ARG;
                end
                else
                begin
                    top_next = req_reg.amount;
                end
            end
            lfsa_pkg::KIND_FREE_BYTES:
            begin
                if (req_reg.amount > avail)
                begin
                    top_next = base_reg;
                end
                else
                begin
                    top_next = top_reg - req_reg.amount;
                end
            end
            lfsa_pkg::KIND_FREE_FRAME:
            begin
                top_next = base_reg;
            end
            lfsa_pkg::KIND_BEGIN:
            begin
                if ((sum_hdr > {1'b0, arena}) || (lvl_reg >= LVL_MAX))
                begin
                    ex_status = lfsa_pkg::ST_NO_ROOM;
                end
                else
                begin
                    mem_wr    = 1'b1;
                    top_next  = sum_hdr[OFS_W-1:0];
                    base_next = sum_hdr[OFS_W-1:0];
                    lvl_next  = lvl_reg + LVL_ONE;
                end
            end
            lfsa_pkg::KIND_END:
            begin
                if ((lvl_reg == '0) || (top_reg == '0))
                begin
                    ex_status = lfsa_pkg::ST_NO_FRAME;
                end
                else
                begin
                    top_next  = base_reg - HDR;
                    base_next = rd_reg;
                    lvl_next  = lvl_dec;
                end
            end
            default:
            begin
                // unroll not downward and the unused kind
                ex_status = lfsa_pkg::ST_BAD_ARG;
            end
        endcase
        ex_result = alloc_ok ? top_reg : top_next;
    end

    // pick what the output register shows
    always_comb
    begin
        if (cmd.fin)
        begin
            f_status = wst_reg;
            f_top    = (wst_reg == lfsa_pkg::ST_OK) ? wt_reg : top_reg;
            f_lvl    = (wst_reg == lfsa_pkg::ST_OK) ? wl_reg : lvl_reg;
            f_result = f_top;
        end
        else
        begin
            f_status = ex_status;
            f_top    = top_next;
            f_lvl    = lvl_next;
            f_result = ex_result;
        end
    end

    // stack read address: level-1 on load, next level-1 on each pop
    assign rd_en   = cmd.load || cmd.pop;
    assign rd_addr = cmd.pop ? wl_dec2[IDX_W-1:0] : lvl_dec[IDX_W-1:0];

    // saved base memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_wr)
        begin
            mem[lvl_reg[IDX_W-1:0]] <= base_reg;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // request latch, unroll working copies, output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            wt_reg  <= top_reg;
            wb_reg  <= base_reg;
            wl_reg  <= lvl_reg;
            wst_reg <= lfsa_pkg::ST_OK;
        end
        else if (cmd.pop)
        begin
            if (wt_reg == '0)
            begin
                wst_reg <= lfsa_pkg::ST_NO_FRAME;
            end
            else
            begin
                wt_reg <= wb_reg - HDR;
                wb_reg <= rd_reg;
                wl_reg <= wl_dec;
            end
        end
        if (cmd.exec || cmd.fin)
        begin
            rsp_reg.status        <= f_status;
            rsp_reg.result_offset <= f_result;
            rsp_reg.frame_level   <= lfsa_pkg::LEVEL_W'(f_lvl);
            rsp_reg.used_bytes    <= f_top;
            rsp_reg.free_bytes    <= (arena > f_top) ? (arena - f_top) : '0;
        end
    end

    // arena register and stack state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg <= lfsa_pkg::ARENA_RESET;
            top_reg   <= '0;
            base_reg  <= '0;
            lvl_reg   <= '0;
        end
        else if (cfg.wr)
        begin
            arena_reg <= cfg.arena;
            top_reg   <= '0;
            base_reg  <= '0;
            lvl_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            top_reg  <= top_next;
            base_reg <= base_next;
            lvl_reg  <= lvl_next;
        end
        else if (cmd.fin && (wst_reg == lfsa_pkg::ST_OK))
        begin
            top_reg  <= wt_reg;
            base_reg <= wb_reg;
            lvl_reg  <= wl_reg;
        end
    end

endmodule

>>> rtl/core/lifo_frame_stack_allocator.sv
// lifo arena allocator with frame markers
// req channel (req_valid, req_stall, req) takes one request item: alloc,
// free to offset, free bytes, free frame, begin frame, end frame or unroll.
// rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one item per
// request: status, result offset, frame level, used and free bytes.
// an item is taken at an edge where valid is high and stall is low.
// kinds other than unroll are written to the output register from the execute
// state once that register is free; an unroll makes one pop of the saved-base
// memory per cycle through its single registered read port, stops early when
// a pop meets an empty top, and then waits in the finish state for the register.
// one request is in work at a time; the next is accepted the cycle after the
// previous one is written to the output register.
// while rsp_stall holds, the output register keeps its item and a finished
// request waits in the controller until the register frees up.
// reset: arena size 65536, top, frame base and level zero, no item pending.
// the apb register arena_bytes lies at address 0; writing it empties the stack.
// the user must write it only while no request is in work; the block does not check.
module lifo_frame_stack_allocator #(
    parameter int MAX_FRAMES   = lfsa_pkg::DEF_MAX_FRAMES,
    parameter int HEADER_BYTES = lfsa_pkg::DEF_HEADER_BYTES,
    parameter int ARENA_MAX    = lfsa_pkg::DEF_ARENA_MAX
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lfsa_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lfsa_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [lfsa_pkg::DATA_W-1:0]   pwdata,
    output logic [lfsa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    lfsa_pkg::dp_cmd_t                cmd;
    lfsa_pkg::dp_sts_t                sts;
    lfsa_pkg::cfg_wr_t                cfg;
    logic [lfsa_pkg::OFS_W-1:0]       arena_bytes;
    logic                             reg_sel;

    // apb register decode
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == lfsa_pkg::REG_ARENA);
    assign cfg.wr    = psel && penable && pwrite && reg_sel;
    assign cfg.arena = pwdata[lfsa_pkg::OFS_W-1:0];
    assign prdata    = reg_sel ? lfsa_pkg::DATA_W'(arena_bytes) : '0;

    lfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lfsa_dpath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .HEADER_BYTES (HEADER_BYTES),
        .ARENA_MAX    (ARENA_MAX)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp),
        .arena_bytes (arena_bytes)
    );

endmodule
